@@ rtl/core/wavetable_voice_mixer_core_assert.svh @@
// Assertion macros used by the checker file.
`ifndef WAVETABLE_VOICE_MIXER_CORE_ASSERT_SVH
`define WAVETABLE_VOICE_MIXER_CORE_ASSERT_SVH

// Consequent must hold in the cycle after the antecedent.
`define WVM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define WVM_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

`endif

@@ rtl/core/wvm_pkg.sv @@
`default_nettype none
package wvm_pkg;

  localparam int VOICES_DEF = 16;
  localparam int SAB_DEF    = 16;

  // Shared multiplier operand and product widths
  localparam int MUL_A_W = 34;
  localparam int MUL_B_W = 18;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  localparam logic [9:0] GAIN_K     = 10'd521;
  localparam logic [7:0] PAN_FULL   = 8'd128;
  localparam logic [6:0] VOL_RESET  = 7'd100;
  localparam logic [6:0] PAN_RESET  = 7'd64;

  // Command codes
  typedef enum logic [2:0] {
    OP_LOAD   = 3'd0,
    OP_START  = 3'd1,
    OP_VOLUME = 3'd2,
    OP_PAN    = 3'd3,
    OP_STOP   = 3'd4,
    OP_RENDER = 3'd5
  } wvm_op_t;

  // Per-voice state word
  typedef struct packed {
    logic [47:0] pos;
    logic [39:0] step;
    logic [15:0] base;
    logic [15:0] len;
    logic [2:0]  fmt;
    logic [6:0]  vel;
    logic [6:0]  vol;
    logic [6:0]  pan;
    logic [14:0] gl;
    logic [14:0] gr;
  } wvm_voice_t;

  localparam int VOICE_W = $bits(wvm_voice_t);

  // Convert one stored sample (low and high byte) to a signed 16-bit value
  function automatic logic signed [15:0] conv(input logic [2:0] fmt,
                                              input logic [7:0] lo,
                                              input logic [7:0] hi);
    logic [15:0] raw;
    begin
      if (fmt[0]) begin
        raw = fmt[2] ? {hi, lo} : {~hi[7], hi[6:0], lo};
      end else begin
        raw = fmt[2] ? {lo, lo ^ 8'h80} : {~lo[7], lo[6:0], lo};
      end
      conv = $signed(raw);
    end
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/wvm_ram.sv @@
`default_nettype none
module wvm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

@@ rtl/core/wvm_mul.sv @@
`default_nettype none
module wvm_mul (
  input  wire logic                             clk,
  input  wire logic signed [wvm_pkg::MUL_A_W-1:0] a,
  input  wire logic signed [wvm_pkg::MUL_B_W-1:0] b,
  output logic signed      [wvm_pkg::PROD_W-1:0]  prod_r
);
  import wvm_pkg::*;

  // Register every product of the shared multiplier
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(a) * PROD_W'(b);
  end

endmodule
`default_nettype wire

@@ rtl/core/wavetable_voice_mixer_core.sv @@
`default_nettype none
// Wavetable voice mixer. Commands on the input stream load sample bytes, start,
// retune or stop voices; a render command yields one saturated stereo frame on
// the output stream. One sequencer drives one shared multiplier and two RAMs
// (sample store, voice state). A load byte is written straight from the input
// and the block stays ready; a voice command runs accept, a state read-modify-write
// plus four multiplies for the pan gains; a render reads each voice state, mixes
// the active voices and is held while a previous frame still waits in the output register.
// The per-voice time is set by the eight single-byte sample reads on the one
// sample store port. Sample store contents are undefined until written.
module wavetable_voice_mixer_core #(
  parameter int VOICES           = wvm_pkg::VOICES_DEF,
  parameter int SAMPLE_ADDR_BITS = wvm_pkg::SAB_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // voice[3:0] address[19:4] mem_byte[27:20] length[43:28] format[46:44]
  // step[86:47] level[93:87], rest zero
  input  wire logic [95:0] in_tdata,
  // op[2:0]
  input  wire logic [2:0]  in_tuser,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // left_sample[15:0] right_sample[31:16] active_voices[47:32]
  output logic      [47:0] out_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data
);
  import wvm_pkg::*;

  localparam int VIDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int AW     = SAMPLE_ADDR_BITS;
  localparam int ACC_W  = 19 + VIDX_W;

  typedef enum logic [18:0] {
    S_IDLE = 19'd1 << 0,
    S_VRD  = 19'd1 << 1,
    S_VLD  = 19'd1 << 2,
    S_G0   = 19'd1 << 3,
    S_G1   = 19'd1 << 4,
    S_G2   = 19'd1 << 5,
    S_G3   = 19'd1 << 6,
    S_G4   = 19'd1 << 7,
    S_FT   = 19'd1 << 8,
    S_FC   = 19'd1 << 9,
    S_IL   = 19'd1 << 10,
    S_IR   = 19'd1 << 11,
    S_GL   = 19'd1 << 12,
    S_GR   = 19'd1 << 13,
    S_WB   = 19'd1 << 14,
    S_MV0  = 19'd1 << 15,
    S_MV1  = 19'd1 << 16,
    S_MV2  = 19'd1 << 17,
    S_OUT  = 19'd1 << 18
  } state_t;

  // Input fields
  logic [2:0]  in_op;
  logic [3:0]  in_voice;
  logic [15:0] in_address;
  logic [7:0]  in_mem_byte;
  logic [15:0] in_length;
  logic [2:0]  in_format;
  logic [39:0] in_step;
  logic [6:0]  in_level;

  assign in_op       = in_tuser;
  assign in_voice    = in_tdata[3:0];
  assign in_address  = in_tdata[19:4];
  assign in_mem_byte = in_tdata[27:20];
  assign in_length   = in_tdata[43:28];
  assign in_format   = in_tdata[46:44];
  assign in_step     = in_tdata[86:47];
  assign in_level    = in_tdata[93:87];

  state_t state_r, state_nxt;
  logic [VIDX_W-1:0] idx_r, idx_nxt;
  logic [2:0]  op_r, op_nxt;
  logic [15:0] cmd_addr_r, cmd_len_r;
  logic [2:0]  cmd_fmt_r;
  logic [39:0] cmd_step_r;
  logic [6:0]  cmd_level_r;
  wvm_voice_t  vw_r, vw_nxt;
  logic [VOICES-1:0] vvalid_r, vvalid_nxt;
  logic [23:0] base_r, base_nxt;
  logic [2:0]  bc_r, bc_nxt;
  logic        cap_v_r;
  logic [2:0]  cap_i_r;
  logic [7:0]  smp_r [8];
  logic signed [15:0] l_r, l_nxt, r_r, r_nxt;
  logic signed [ACC_W-1:0] accl_r, accl_nxt, accr_r, accr_nxt;
  logic [15:0] active_r, active_nxt;
  logic [15:0] res_l_r, res_l_nxt, res_r_r, res_r_nxt;
  logic [7:0]  master_r;
  logic        out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;

  logic             vram_we;
  logic [VOICE_W-1:0] vram_rdata;
  wvm_voice_t       vram_word, vram_wdata;
  logic [AW-1:0]    s_raddr;
  logic [7:0]       s_rdata;
  logic             s_we;

  logic        accept;
  logic [15:0] cur_i, cur_nx;
  logic [16:0] i_inc;
  logic [15:0] cur_frac;
  logic [15:0] fidx;
  logic [1:0]  fsh;
  logic [31:0] foff;
  logic [48:0] np;
  logic signed [15:0] a0, b0, a1, b1;
  logic signed [16:0] d0, d1;
  logic signed [PROD_W-1:0] isum, psh;

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Sample store, written by load commands straight from the input
  assign s_we = accept && (in_op == OP_LOAD);

  wvm_ram #(.WIDTH(8), .DEPTH(1 << AW), .AW(AW)) u_sram (
    .clk   (clk),
    .we    (s_we),
    .waddr (AW'(in_address)),
    .wdata (in_mem_byte),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  wvm_ram #(.WIDTH(VOICE_W), .DEPTH(VOICES), .AW(VIDX_W)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (idx_r),
    .wdata (vram_wdata),
    .raddr (idx_r),
    .rdata (vram_rdata)
  );

  wvm_mul u_mul (
    .clk    (clk),
    .a      (mul_a),
    .b      (mul_b),
    .prod_r (prod_r)
  );

  // Unwritten voice entries read as their reset word
  always_comb begin
    vram_word = '0;
    vram_word.vol = VOL_RESET;
    vram_word.pan = PAN_RESET;
    if (vvalid_r[idx_r]) begin
      vram_word = vram_rdata;
    end
  end

  // Frame index, next index and fraction of the current voice
  assign cur_i    = vw_r.pos[47:32];
  assign cur_frac = vw_r.pos[31:16];
  assign i_inc    = {1'b0, cur_i} + 17'd1;
  assign cur_nx   = (i_inc >= {1'b0, vw_r.len}) ? cur_i : i_inc[15:0];

  // Byte address for fetch slot: bit0 high byte, bit1 next frame, bit2 channel
  assign fidx = bc_r[1] ? cur_nx : cur_i;
  assign fsh  = {1'b0, vw_r.fmt[0]} + {1'b0, vw_r.fmt[1]};
  always_comb begin
    foff = {16'b0, fidx} << fsh;
    if (bc_r[2] && vw_r.fmt[1]) begin
      foff = foff + (vw_r.fmt[0] ? 32'd2 : 32'd1);
    end
    foff = foff + {31'b0, bc_r[0]} + {16'b0, vw_r.base};
    s_raddr = foff[AW-1:0];
  end

  // Converted samples and differences
  assign a0 = conv(vw_r.fmt, smp_r[0], smp_r[1]);
  assign b0 = conv(vw_r.fmt, smp_r[2], smp_r[3]);
  assign a1 = conv(vw_r.fmt, smp_r[4], smp_r[5]);
  assign b1 = conv(vw_r.fmt, smp_r[6], smp_r[7]);
  assign d0 = 17'(b0) - 17'(a0);
  assign d1 = 17'(b1) - 17'(a1);
  assign psh = prod_r >>> 16;

  assign np = {1'b0, vw_r.pos} + {9'b0, vw_r.step};

  function automatic logic [15:0] sat16(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] s;
    begin
      s = p >>> 7;
      if (s < -PROD_W'(32768)) begin
        sat16 = 16'h8000;
      end else if (s > PROD_W'(32767)) begin
        sat16 = 16'h7fff;
      end else begin
        sat16 = s[15:0];
      end
    end
  endfunction

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    op_nxt        = op_r;
    vw_nxt        = vw_r;
    vvalid_nxt    = vvalid_r;
    base_nxt      = base_r;
    bc_nxt        = bc_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    accl_nxt      = accl_r;
    accr_nxt      = accr_r;
    active_nxt    = active_r;
    res_l_nxt     = res_l_r;
    res_r_nxt     = res_r_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mul_a         = '0;
    mul_b         = '0;
    vram_we       = 1'b0;
    vram_wdata    = vw_r;
    isum          = '0;

    // Drop the result once taken
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt = in_op;
          if ((in_op inside {OP_START, OP_VOLUME, OP_PAN, OP_STOP}) &&
              (32'(in_voice) < VOICES)) begin
            idx_nxt   = VIDX_W'(in_voice);
            state_nxt = S_VRD;
          end else if (in_op == OP_RENDER) begin
            idx_nxt    = '0;
            accl_nxt   = '0;
            accr_nxt   = '0;
            active_nxt = '0;
            state_nxt  = S_VRD;
          end
        end
      end
      S_VRD: state_nxt = S_VLD;
      S_VLD: begin
        vw_nxt = vram_word;
        case (op_r)
          OP_START: begin
            vw_nxt.base = cmd_addr_r;
            vw_nxt.len  = cmd_len_r;
            vw_nxt.fmt  = cmd_fmt_r;
            vw_nxt.step = cmd_step_r;
            vw_nxt.pos  = '0;
            vw_nxt.vel  = (cmd_len_r != 16'd0) ? cmd_level_r : 7'd0;
            state_nxt   = S_G0;
          end
          OP_VOLUME: begin
            vw_nxt.vol = cmd_level_r;
            state_nxt  = S_G0;
          end
          OP_PAN: begin
            vw_nxt.pan = cmd_level_r;
            state_nxt  = S_G0;
          end
          OP_STOP: begin
            vw_nxt.vel = 7'd0;
            state_nxt  = S_G0;
          end
          default: begin
            // Render: skip silent voices
            if (vram_word.vel == 7'd0) begin
              if (idx_r == VIDX_W'(VOICES - 1)) begin
                state_nxt = S_MV0;
              end else begin
                idx_nxt   = idx_r + 1'b1;
                state_nxt = S_VRD;
              end
            end else begin
              bc_nxt    = '0;
              state_nxt = S_FT;
            end
          end
        endcase
      end
      // Gain update: vol*vel, *521, *(128-pan), *pan
      S_G0: begin
        mul_a     = MUL_A_W'(vw_r.vol);
        mul_b     = MUL_B_W'(vw_r.vel);
        state_nxt = S_G1;
      end
      S_G1: begin
        mul_a     = MUL_A_W'(prod_r[13:0]);
        mul_b     = MUL_B_W'(GAIN_K);
        state_nxt = S_G2;
      end
      S_G2: begin
        base_nxt  = prod_r[23:0];
        mul_a     = MUL_A_W'(prod_r[23:0]);
        mul_b     = MUL_B_W'(PAN_FULL - {1'b0, vw_r.pan});
        state_nxt = S_G3;
      end
      S_G3: begin
        vw_nxt.gl = prod_r[30:16];
        mul_a     = MUL_A_W'(base_r);
        mul_b     = MUL_B_W'(vw_r.pan);
        state_nxt = S_G4;
      end
      S_G4: begin
        vw_nxt.gr = prod_r[30:16];
        state_nxt = S_WB;
      end
      // Issue the eight sample byte reads
      S_FT: begin
        bc_nxt = bc_r + 3'd1;
        if (bc_r == 3'd7) begin
          state_nxt = S_FC;
        end
      end
      S_FC: state_nxt = S_IL;
      S_IL: begin
        mul_a     = MUL_A_W'(d0);
        mul_b     = MUL_B_W'({2'b0, cur_frac});
        state_nxt = S_IR;
      end
      S_IR: begin
        isum      = PROD_W'(a0) + psh;
        l_nxt     = isum[15:0];
        mul_a     = MUL_A_W'(d1);
        mul_b     = MUL_B_W'({2'b0, cur_frac});
        state_nxt = S_GL;
      end
      S_GL: begin
        isum = PROD_W'(a1) + psh;
        r_nxt = vw_r.fmt[1] ? isum[15:0] : l_r;
        mul_a     = MUL_A_W'(l_r);
        mul_b     = MUL_B_W'({3'b0, vw_r.gl});
        state_nxt = S_GR;
      end
      S_GR: begin
        accl_nxt  = accl_r + ACC_W'(prod_r >>> 13);
        mul_a     = MUL_A_W'(r_r);
        mul_b     = MUL_B_W'({3'b0, vw_r.gr});
        state_nxt = S_WB;
      end
      S_WB: begin
        vram_we = 1'b1;
        vvalid_nxt[idx_r] = 1'b1;
        if (op_r == OP_RENDER) begin
          accr_nxt = accr_r + ACC_W'(prod_r >>> 13);
          // Advance position; stop at the sample end
          if (np[48:32] >= {1'b0, vw_r.len}) begin
            vram_wdata.vel = 7'd0;
          end else begin
            vram_wdata.pos = np[47:0];
            if (32'(idx_r) < 16) begin
              active_nxt[4'(idx_r)] = 1'b1;
            end
          end
          if (idx_r == VIDX_W'(VOICES - 1)) begin
            state_nxt = S_MV0;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = S_VRD;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      // Master volume and saturation
      S_MV0: begin
        mul_a     = MUL_A_W'(accl_r);
        mul_b     = MUL_B_W'(master_r);
        state_nxt = S_MV1;
      end
      S_MV1: begin
        res_l_nxt = sat16(prod_r);
        mul_a     = MUL_A_W'(accr_r);
        mul_b     = MUL_B_W'(master_r);
        state_nxt = S_MV2;
      end
      S_MV2: begin
        res_r_nxt = sat16(prod_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {active_r, res_r_r, res_l_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vvalid_r    <= '0;
      out_valid_r <= 1'b0;
      master_r    <= '0;
      cap_v_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      vvalid_r    <= vvalid_nxt;
      out_valid_r <= out_valid_nxt;
      cap_v_r     <= (state_r == S_FT);
      if (cfg_valid && cfg_ready) begin
        master_r <= cfg_data;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    op_r       <= op_nxt;
    vw_r       <= vw_nxt;
    base_r     <= base_nxt;
    bc_r       <= bc_nxt;
    cap_i_r    <= bc_r;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    accl_r     <= accl_nxt;
    accr_r     <= accr_nxt;
    active_r   <= active_nxt;
    res_l_r    <= res_l_nxt;
    res_r_r    <= res_r_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_addr_r  <= in_address;
      cmd_len_r   <= in_length;
      cmd_fmt_r   <= in_format;
      cmd_step_r  <= in_step;
      cmd_level_r <= in_level;
    end
    if (cap_v_r) begin
      smp_r[cap_i_r] <= s_rdata;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/wvm_checker.sv @@
`default_nettype none
`include "wavetable_voice_mixer_core_assert.svh"
module wvm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [2:0]  in_tuser,
  input wire logic        out_tvalid,
  input wire logic        out_tready
);
  import wvm_pkg::*;

  // A stalled result stays offered
  `WVM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  // A render request keeps the block busy afterwards
  `WVM_ASSERT_NEXT(a_render_busy, clk, rst_n, in_tvalid && in_tready && in_tuser == OP_RENDER, !in_tready)
  // A new result appears only at the end of a busy period
  `WVM_ASSERT_NOW(a_out_after_busy, clk, rst_n, $rose(out_tvalid), $past(!in_tready))
  // A stop command never produces a result right away
  `WVM_ASSERT_NEXT(a_cmd_quiet, clk, rst_n, in_tvalid && in_tready && in_tuser == OP_STOP && !out_tvalid, !out_tvalid)

endmodule

bind wavetable_voice_mixer_core wvm_checker u_wvm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready)
);
`default_nettype wire

@@ tb/tb_wavetable_voice_mixer_core.sv @@
`timescale 1ns / 1ps
module tb_wavetable_voice_mixer_core;
  import wvm_pkg::*;

  localparam int NVOICE = 16;

  // One command request on the input stream
  typedef struct {
    logic [2:0]  op;
    logic [3:0]  voice;
    logic [15:0] address;
    logic [7:0]  mem_byte;
    logic [15:0] length;
    logic [2:0]  format;
    logic [39:0] step;
    logic [6:0]  level;
  } cmd_t;

  typedef struct {
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] active;
  } frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [95:0] in_tdata = '0;
  logic [2:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [7:0] cfg_data = '0;

  wavetable_voice_mixer_core i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Mixer shadow state
  logic [7:0]  mem [0:65535];
  logic [47:0] v_pos [NVOICE];
  logic [39:0] v_step [NVOICE];
  logic [15:0] v_base [NVOICE];
  logic [15:0] v_len [NVOICE];
  logic [2:0]  v_fmt [NVOICE];
  logic [6:0]  v_vel [NVOICE];
  logic [6:0]  v_vol [NVOICE];
  logic [6:0]  v_pan [NVOICE];
  logic [14:0] v_gl [NVOICE];
  logic [14:0] v_gr [NVOICE];
  logic [7:0]  master_gain;

  cmd_t   pending_cmds [$];
  frame_t expected_frames [$];
  int     mismatches = 0;
  bit     failed = 1'b0;
  bit     hold_off = 1'b0;
  int     phase = 0;
  int     sent_cnt = 0;
  int     taken_cnt = 0;

  function automatic void recompute_gains(int v);
    logic [31:0] g;
    logic [31:0] t;
    g = 32'(v_vol[v]) * 32'(v_vel[v]) * 32'd521;
    t = g * (32'd128 - 32'(v_pan[v]));
    v_gl[v] = 15'(t >> 16);
    t = g * 32'(v_pan[v]);
    v_gr[v] = 15'(t >> 16);
  endfunction

  // Converted 16-bit value of one channel of one frame
  function automatic int sample_value(int v, logic [15:0] idx, int ch);
    logic [2:0]  f;
    logic [31:0] off;
    logic [15:0] a;
    logic [7:0]  b0, b1;
    logic [15:0] raw;
    f = v_fmt[v];
    off = 32'(idx) * (f[0] ? 2 : 1) * (f[1] ? 2 : 1) + (f[1] ? ch * (f[0] ? 2 : 1) : 0);
    a = 16'(32'(v_base[v]) + off);
    b0 = mem[a];
    b1 = mem[16'(a + 16'd1)];
    if (f[0]) raw = f[2] ? {b1, b0} : {b1, b0} ^ 16'h8000;
    else raw = f[2] ? {b0, b0 ^ 8'h80} : {b0, b0} ^ 16'h8000;
    return int'($signed(raw));
  endfunction

  function automatic longint lerp(int v, logic [15:0] i, logic [15:0] nx, longint frac, int ch);
    longint a, b;
    a = sample_value(v, i, ch);
    b = sample_value(v, nx, ch);
    return (a * (65536 - frac) + b * frac) >>> 16;
  endfunction

  function automatic logic [15:0] clip16(longint x);
    if (x < -32768) x = -32768;
    if (x > 32767) x = 32767;
    return 16'(x);
  endfunction

  // Apply one command to the shadow state, queue a frame for a render
  function automatic void mixer_apply(cmd_t c);
    longint accl, accr, frac, l, r;
    logic [15:0] act, i, nx;
    logic [48:0] np;
    frame_t fr;
    int v;
    v = c.voice;
    case (c.op)
      OP_LOAD: begin
        mem[c.address] = c.mem_byte;
      end
      OP_START, OP_VOLUME, OP_PAN, OP_STOP: begin
        if (c.op == OP_START) begin
          v_base[v] = c.address;
          v_len[v] = c.length;
          v_fmt[v] = c.format;
          v_step[v] = c.step;
          v_pos[v] = '0;
          v_vel[v] = (c.length != 0) ? c.level : 7'd0;
        end else if (c.op == OP_VOLUME) v_vol[v] = c.level;
        else if (c.op == OP_PAN) v_pan[v] = c.level;
        else v_vel[v] = '0;
        recompute_gains(v);
      end
      OP_RENDER: begin
        accl = 0;
        accr = 0;
        act = '0;
        for (int k = 0; k < NVOICE; k++) begin
          if (v_vel[k] != 0) begin
            i = v_pos[k][47:32];
            frac = longint'(v_pos[k][31:16]);
            nx = (32'(i) + 1 >= 32'(v_len[k])) ? i : i + 16'd1;
            l = lerp(k, i, nx, frac, 0);
            r = v_fmt[k][1] ? lerp(k, i, nx, frac, 1) : l;
            accl += (l * longint'(v_gl[k])) >>> 13;
            accr += (r * longint'(v_gr[k])) >>> 13;
            np = 49'(v_pos[k]) + 49'(v_step[k]);
            if (np[48:32] >= 17'(v_len[k])) v_vel[k] = '0;
            else begin
              v_pos[k] = np[47:0];
              act[k] = 1'b1;
            end
          end
        end
        fr.left = clip16((accl * longint'(master_gain)) >>> 7);
        fr.right = clip16((accr * longint'(master_gain)) >>> 7);
        fr.active = act;
        expected_frames.push_back(fr);
      end
      default: ;
    endcase
  endfunction

  // Driver: bursts of requests with random gaps
  int burst_left = 0;
  int gap_left = 0;
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_tvalid && (taken_cnt != sent_cnt)) begin
        // hold the request
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_tvalid <= 1'b0;
      end else if (pending_cmds.size() > 0) begin
        cmd_t c;
        c = pending_cmds.pop_front();
        in_tuser <= c.op;
        in_tdata <= {2'b00, c.level, c.step, c.format, c.length, c.mem_byte, c.address, c.voice};
        in_tvalid <= 1'b1;
        sent_cnt++;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(30, 1);
          gap_left <= ($urandom_range(3) == 0) ? 0 : $urandom_range(6, 1);
        end else burst_left <= burst_left - 1;
      end else in_tvalid <= 1'b0;
    end
  end

  // Accepted request goes into the predictor at the edge it is taken
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      cmd_t c;
      c.op = in_tuser;
      {c.level, c.step, c.format, c.length, c.mem_byte, c.address, c.voice} = in_tdata[93:0];
      mixer_apply(c);
      taken_cnt++;
    end
  end

  // Receiver stall pattern
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase <= stall_phase + 1;
    if (hold_off) out_tready <= 1'b0;
    else if (stall_phase[9]) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(3) != 0) && !(stall_phase[4:2] == 3'd5);
  end

  // Long receiver hold-off during the third random phase
  initial begin
    wait (phase == 3);
    repeat (50) @(posedge clk);
    hold_off = 1'b1;
    repeat (3000) @(posedge clk);
    hold_off = 1'b0;
  end

  // Monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      frame_t e;
      if (expected_frames.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected frame %h", out_tdata);
      end else begin
        e = expected_frames.pop_front();
        if (out_tdata !== {e.active, e.right, e.left}) begin
          failed = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("frame mismatch: exp L=%h R=%h act=%h got L=%h R=%h act=%h",
                     e.left, e.right, e.active,
                     out_tdata[15:0], out_tdata[31:16], out_tdata[47:32]);
        end
      end
    end
  end

  function automatic cmd_t mk(logic [2:0] op, int v, logic [15:0] a, logic [7:0] b,
                              logic [15:0] len, logic [2:0] f, logic [39:0] st,
                              logic [6:0] lvl);
    cmd_t c;
    c.op = op; c.voice = 4'(v); c.address = a; c.mem_byte = b;
    c.length = len; c.format = f; c.step = st; c.level = lvl;
    return c;
  endfunction

  function automatic logic [39:0] rand_step();
    logic [39:0] s;
    s = 40'({$urandom, $urandom});
    case ($urandom_range(4))
      0: s = s & 40'h00_FFFF_FFFF;
      1: s = s & 40'h01_FFFF_FFFF;
      2: s = s & 40'h03_FFFF_FFFF;
      3: s = s & 40'h00_3FFF_FFFF;
      default: ;
    endcase
    return s;
  endfunction

  // Random command with junk in unused fields; start keeps reads inside written bytes
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int sel;
    c = mk(3'($urandom), $urandom, 16'($urandom), 8'($urandom), 16'($urandom),
           3'($urandom), 40'({$urandom, $urandom}), 7'($urandom));
    sel = $urandom_range(99);
    if (sel < 20) begin
      c.op = OP_LOAD;
      c.address = 16'($urandom_range(1023));
    end else if (sel < 32) begin
      c.op = OP_START;
      c.length = ($urandom_range(15) == 0) ? 16'd0 : 16'($urandom_range(64, 1));
      c.address = 16'($urandom_range(1024 - 4 * int'(c.length)));
      if ($urandom_range(30) == 0) c.level = 7'd0;
      c.step = rand_step();
    end else if (sel < 38) c.op = OP_VOLUME;
    else if (sel < 44) c.op = OP_PAN;
    else if (sel < 47) c.op = OP_STOP;
    else if (sel < 98) c.op = OP_RENDER;
    else c.op = 3'(6 + $urandom_range(1));
    return c;
  endfunction

  task automatic write_master(logic [7:0] val);
    @(negedge clk);
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    master_gain = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Wait until the block has drained everything sent so far
  task automatic drain();
    while (pending_cmds.size() > 0 || in_tvalid || expected_frames.size() > 0)
      @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  initial begin
    logic [7:0] gains [5];
    gains = '{8'd0, 8'd128, 8'd255, 8'd64, 8'd100};
    for (int v = 0; v < NVOICE; v++) begin
      v_pos[v] = '0; v_step[v] = '0; v_base[v] = '0; v_len[v] = '0; v_fmt[v] = '0;
      v_vel[v] = '0; v_vol[v] = VOL_RESET; v_pan[v] = PAN_RESET; v_gl[v] = '0; v_gr[v] = '0;
    end
    master_gain = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    write_master(8'd128);

    // Directed: fill 1 KiB of samples including extremes, then one voice per format
    for (int a = 0; a < 1024; a++) begin
      logic [7:0] b;
      b = (a % 4 == 0) ? 8'h00 : (a % 4 == 1) ? 8'hFF : (a % 4 == 2) ? 8'h80 : 8'($urandom);
      pending_cmds.push_back(mk(OP_LOAD, 0, 16'(a), b, 16'hFFFF, 3'h7, '1, 7'h7F));
    end
    for (int f = 0; f < 8; f++)
      pending_cmds.push_back(mk(OP_START, f, 16'(f * 100), 0, 16'(4 + f), 3'(f),
                                40'h00_8000_0000 + 40'(f) * 40'h00_3000_0000, 7'd127));
    pending_cmds.push_back(mk(OP_START, 8, 16'd0, 0, 16'd0, 3'd0, 40'h1_0000_0000, 7'd127));
    pending_cmds.push_back(mk(OP_START, 9, 16'd0, 0, 16'd5, 3'd0, 40'h1_0000_0000, 7'd0));
    pending_cmds.push_back(mk(OP_START, 10, 16'd900, 0, 16'd2, 3'd3, 40'hFF_FFFF_FFFF, 7'd127));
    pending_cmds.push_back(mk(OP_VOLUME, 0, 0, 0, 0, 0, 0, 7'd127));
    pending_cmds.push_back(mk(OP_PAN, 1, 0, 0, 0, 0, 0, 7'd0));
    pending_cmds.push_back(mk(OP_PAN, 2, 0, 0, 0, 0, 0, 7'd127));
    pending_cmds.push_back(mk(OP_STOP, 7, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(3'd6, 1, 0, 0, 0, 0, 0, 0));
    pending_cmds.push_back(mk(3'd7, 1, 0, 0, 0, 0, 0, 0));
    for (int k = 0; k < 8; k++) pending_cmds.push_back(mk(OP_RENDER, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // Random phases under several master gains; one long receiver hold-off
    for (int ph = 0; ph < 5; ph++) begin
      write_master(gains[ph]);
      phase = ph + 1;
      for (int n = 0; n < 100; n++) pending_cmds.push_back(rand_cmd());
      drain();
    end
    if (!failed) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
